@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// same with a message of its own
`define ASSERT_CLK_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_MSG(label, clk, rst, prop, msg)

`endif

`endif

@@ rtl/core/bthalloc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bthalloc_pkg;

   // widest table address any configuration may need
   localparam int TBL_ADDR_W = 16;

   localparam int ADDR_W          = 32;
   localparam int HEAP_BLOCKS_W   = 11;
   localparam int COUNT_W         = 11;
   localparam int HEAP_BLOCKS_RST = 1024;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BLOCKS = 1'b1;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD_REQ  = 2'd2
   } status_type;

   typedef struct packed {
      logic first;
      logic has_next;
      logic taken;
   } entry_type;

   typedef struct packed {
      logic                  rd_en;
      logic [TBL_ADDR_W-1:0] rd_addr;
      logic                  wr_en;
      logic [TBL_ADDR_W-1:0] wr_addr;
      entry_type             wr_data;
   } tbl_req_type;

endpackage

`default_nettype wire

@@ rtl/core/bthalloc_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bthalloc_table #(
   parameter int MAX_BLOCKS = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bthalloc_pkg::tbl_req_type tbl_req,
   output bthalloc_pkg::entry_type        rd_data,
   output logic                           init_done
);
   import bthalloc_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);

   entry_type mem [MAX_BLOCKS];
   entry_type rd_data_ff;

   logic             clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   // sweep the table to all free after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == IDX_W'(MAX_BLOCKS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_idx_ff;
         wr_data = '0;
      end else begin
         wr_en   = tbl_req.wr_en;
         wr_addr = tbl_req.wr_addr[IDX_W-1:0];
         wr_data = tbl_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[tbl_req.rd_addr[IDX_W-1:0]];
      end
   end

   assign rd_data   = rd_data_ff;
   assign init_done = !clr_busy_ff;

   `ASSERT_CLK_MSG(a_no_access_in_clear, clock, reset, clr_busy_ff |-> !tbl_req.rd_en && !tbl_req.wr_en, "table accessed during clear")
   `ASSERT_CLK(a_rw_distinct, clock, reset, (tbl_req.rd_en && tbl_req.wr_en) |-> (tbl_req.rd_addr != tbl_req.wr_addr))
   `ASSERT_CLK(a_clear_ends_at_top, clock, reset, $fell(clr_busy_ff) |-> ($past(clr_idx_ff) == IDX_W'(MAX_BLOCKS - 1)))

endmodule

`default_nettype wire

@@ rtl/core/bthalloc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bthalloc_ctrl #(
   parameter int BLOCK_BYTES = 4096,
   parameter int MAX_BLOCKS  = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  init_done,
   input  wire logic [bthalloc_pkg::ADDR_W-1:0]       heap_base,
   input  wire logic [$clog2(MAX_BLOCKS+1)-1:0]       limit,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_action,
   input  wire logic [bthalloc_pkg::ADDR_W-1:0]       req_request_bytes,
   input  wire logic [bthalloc_pkg::ADDR_W-1:0]       req_free_address,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [bthalloc_pkg::ADDR_W-1:0]            rsp_result_address,
   output logic [1:0]                                 rsp_status,
   output logic [bthalloc_pkg::COUNT_W-1:0]           rsp_blocks_changed,
   output bthalloc_pkg::tbl_req_type                  tbl_req,
   input  wire bthalloc_pkg::entry_type               tbl_rdata
);
   import bthalloc_pkg::*;

   localparam int IDX_W     = $clog2(MAX_BLOCKS);
   localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
   localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int NEED_W    = ADDR_W + 1 - BLK_SHIFT;
   localparam int BLK_W     = ADDR_W - BLK_SHIFT;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_MARK,
      S_FREE,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic              action_ff, action_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              below_ff, below_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [IDX_W-1:0]  ev_idx_ff, ev_idx_in;
   logic [CNT_W-1:0]  run_ff, run_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic [IDX_W-1:0]  end_ff, end_in;
   logic              first_ff, first_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        res_status_ff, res_status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [ADDR_W:0]   bytes_sum;
   logic [ADDR_W-1:0] free_off;
   logic [CNT_W-1:0]  run_nx;
   logic              at_last;

   assign bytes_sum = {1'b0, req_request_bytes} + (ADDR_W + 1)'(BLOCK_BYTES - 1);
   assign free_off  = req_free_address - heap_base;
   assign run_nx    = run_ff + CNT_W'(1);
   assign at_last   = (CNT_W'(ev_idx_ff) + CNT_W'(1)) == limit;
   assign req_ready = (state_ff == S_IDLE) && init_done;

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      need_in       = need_ff;
      below_in      = below_ff;
      blk_in        = blk_ff;
      ev_idx_in     = ev_idx_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      tbl_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               action_in = req_action;
               need_in   = bytes_sum[ADDR_W:BLK_SHIFT];
               below_in  = req_free_address < heap_base;
               blk_in    = free_off[ADDR_W-1:BLK_SHIFT];
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            count_in = '0;
            run_in   = '0;
            start_in = '0;
            first_in = 1'b1;
            if (action_ff == ACT_ALLOC) begin
               if ((need_ff == '0) || (need_ff > NEED_W'(limit))) begin
                  res_status_in = ST_NO_SPACE;
                  state_in      = S_RESP;
               end else begin
                  tbl_req.rd_en   = 1'b1;
                  tbl_req.rd_addr = '0;
                  ev_idx_in       = '0;
                  state_in        = S_SCAN;
               end
            end else begin
               if (below_ff || ((ADDR_W + 1)'(blk_ff) >= (ADDR_W + 1)'(limit))) begin
                  res_status_in = ST_BAD_REQ;
                  state_in      = S_RESP;
               end else begin
                  tbl_req.rd_en   = 1'b1;
                  tbl_req.rd_addr = TBL_ADDR_W'(blk_ff[IDX_W-1:0]);
                  ev_idx_in       = blk_ff[IDX_W-1:0];
                  state_in        = S_FREE;
               end
            end
         end
         S_SCAN: begin
            // read data here belongs to ev_idx_ff; the read of the next entry is issued here
            if (tbl_rdata.taken) begin
               run_in   = '0;
               start_in = ev_idx_ff + IDX_W'(1);
            end else begin
               run_in = run_nx;
            end
            if (!tbl_rdata.taken && (run_nx == need_ff[CNT_W-1:0])) begin
               end_in        = ev_idx_ff;
               count_in      = run_nx;
               ev_idx_in     = start_ff;
               res_status_in = ST_OK;
               state_in      = S_MARK;
            end else if (at_last) begin
               res_status_in = ST_NO_SPACE;
               state_in      = S_RESP;
            end else begin
               tbl_req.rd_en   = 1'b1;
               tbl_req.rd_addr = TBL_ADDR_W'(ev_idx_ff + IDX_W'(1));
               ev_idx_in       = ev_idx_ff + IDX_W'(1);
            end
         end
         S_MARK: begin
            tbl_req.wr_en            = 1'b1;
            tbl_req.wr_addr          = TBL_ADDR_W'(ev_idx_ff);
            tbl_req.wr_data.taken    = 1'b1;
            tbl_req.wr_data.has_next = ev_idx_ff != end_ff;
            tbl_req.wr_data.first    = ev_idx_ff == start_ff;
            if (ev_idx_ff == end_ff) begin
               state_in = S_RESP;
            end else begin
               ev_idx_in = ev_idx_ff + IDX_W'(1);
            end
         end
         S_FREE: begin
            first_in = 1'b0;
            if (!tbl_rdata.taken) begin
               res_status_in = first_ff ? ST_BAD_REQ : ST_OK;
               state_in      = S_RESP;
            end else if (!first_ff && tbl_rdata.first) begin
               // next run begins here
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end else begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_addr = TBL_ADDR_W'(ev_idx_ff);
               tbl_req.wr_data = '0;
               count_in        = count_ff + CNT_W'(1);
               if (!tbl_rdata.has_next || at_last) begin
                  res_status_in = ST_OK;
                  state_in      = S_RESP;
               end else begin
                  tbl_req.rd_en   = 1'b1;
                  tbl_req.rd_addr = TBL_ADDR_W'(ev_idx_ff + IDX_W'(1));
                  ev_idx_in       = ev_idx_ff + IDX_W'(1);
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               if (res_status_ff == ST_OK) begin
                  rsp_count_in = COUNT_W'(count_ff);
               end else begin
                  rsp_count_in = '0;
               end
               if ((res_status_ff == ST_OK) && (action_ff == ACT_ALLOC)) begin
                  rsp_addr_in = heap_base + ADDR_W'({start_ff, {BLK_SHIFT{1'b0}}});
               end else begin
                  rsp_addr_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff     <= action_in;
      need_ff       <= need_in;
      below_ff      <= below_in;
      blk_ff        <= blk_in;
      ev_idx_ff     <= ev_idx_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      first_ff      <= first_in;
      count_ff      <= count_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_blocks_changed = rsp_count_ff;

   `ASSERT_CLK(a_fail_is_zero, clock, reset, (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> ((rsp_addr_ff == '0) && (rsp_count_ff == '0)))
   `ASSERT_CLK(a_run_below_need, clock, reset, (state_ff == S_SCAN) |-> (NEED_W'(run_ff) < need_ff))
   `ASSERT_CLK(a_write_only_in_update, clock, reset, tbl_req.wr_en |-> ((state_ff == S_MARK) || (state_ff == S_FREE)))

endmodule

`default_nettype wire

@@ rtl/core/block_table_heap_allocator_top.sv @@
// allocate: the table is scanned for a run of free blocks, over at most min(heap_blocks,
//   MAX_BLOCKS) entries, then the granted blocks are marked; free releases blocks until the
//   run ends, and the walk may stop at a block that it leaves in place
// throughput: one transaction at a time, the next is accepted from the same cycle in which
//   the previous response is loaded; the table is read one entry per cycle via its read port
// reset: synchronous; the table is then cleared one entry per cycle, all MAX_BLOCKS entries
`timescale 1ns / 1ps
`default_nettype none

module block_table_heap_allocator_top #(
   parameter int BLOCK_BYTES = 4096,
   parameter int MAX_BLOCKS  = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [bthalloc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bthalloc_pkg::ADDR_W-1:0]        csr_wdata,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_action,
   input  wire logic [bthalloc_pkg::ADDR_W-1:0]        req_request_bytes,
   input  wire logic [bthalloc_pkg::ADDR_W-1:0]        req_free_address,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [bthalloc_pkg::ADDR_W-1:0]             rsp_result_address,
   output logic [1:0]                                  rsp_status,
   output logic [bthalloc_pkg::COUNT_W-1:0]            rsp_blocks_changed
);
   import bthalloc_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int LIMIT_RST_INT =
      (MAX_BLOCKS < HEAP_BLOCKS_RST) ? MAX_BLOCKS : HEAP_BLOCKS_RST;
   localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(LIMIT_RST_INT);

   logic [ADDR_W-1:0] heap_base_ff, heap_base_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic [ADDR_W-1:0] blocks_wr;

   tbl_req_type tbl_req;
   entry_type   tbl_rdata;
   logic        init_done;

   // only the low HEAP_BLOCKS_W bits of the written size are used; the stored size is clamped to the physical depth
   assign blocks_wr = ADDR_W'(csr_wdata[HEAP_BLOCKS_W-1:0]);

   always_comb begin
      heap_base_in = heap_base_ff;
      limit_in     = limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEAP_BASE: begin
               heap_base_in = csr_wdata;
            end
            CSR_HEAP_BLOCKS: begin
               limit_in = (blocks_wr > ADDR_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                             : CNT_W'(blocks_wr);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         limit_ff     <= LIMIT_RST;
      end else begin
         heap_base_ff <= heap_base_in;
         limit_ff     <= limit_in;
      end
   end

   bthalloc_ctrl #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .MAX_BLOCKS  (MAX_BLOCKS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .init_done          (init_done),
      .heap_base          (heap_base_ff),
      .limit              (limit_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_request_bytes  (req_request_bytes),
      .req_free_address   (req_free_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .rsp_blocks_changed (rsp_blocks_changed),
      .tbl_req            (tbl_req),
      .tbl_rdata          (tbl_rdata)
   );

   bthalloc_table #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .tbl_req   (tbl_req),
      .rd_data   (tbl_rdata),
      .init_done (init_done)
   );

endmodule

`default_nettype wire
